// ===== hw/rtl/ate_pkg.sv =====
// ----------------------------------------------------------------------------
// ate_pkg
// Shared widths, codes, payload types and the controller/datapath bundles
// of the array table engine.
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam int ATE_CAPACITY = 64;

  localparam int KIND_W   = 3;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;

  typedef logic        [KIND_W-1:0]   ate_kind_t;
  typedef logic signed [WORD_W-1:0]   ate_word_t;
  typedef logic        [POS_W-1:0]    ate_pos_t;
  typedef logic        [STATUS_W-1:0] ate_status_t;
  typedef logic        [FILL_W-1:0]   ate_fill_t;

  localparam ate_kind_t KIND_SEARCH = 3'd0;
  localparam ate_kind_t KIND_APPEND = 3'd1;
  localparam ate_kind_t KIND_MODIFY = 3'd2;
  localparam ate_kind_t KIND_REMOVE = 3'd3;
  localparam ate_kind_t KIND_ZERO   = 3'd4;

  localparam ate_status_t ST_OK        = 2'd0;
  localparam ate_status_t ST_NOT_FOUND = 2'd1;
  localparam ate_status_t ST_FULL      = 2'd2;
  localparam ate_status_t ST_RANGE     = 2'd3;

  // read address source
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_POS,
    RD_NEXT
  } ate_rd_sel_t;

  // write address source
  typedef enum logic [1:0] {
    WA_TAIL,
    WA_POS,
    WA_PREV
  } ate_wa_sel_t;

  // write data source
  typedef enum logic [1:0] {
    WD_VALUE,
    WD_ZERO,
    WD_READ
  } ate_wd_sel_t;

  typedef struct packed {
    logic        load_req;
    logic        clear_res;
    logic        rd_en;
    ate_rd_sel_t rd_sel;
    logic        wr_en;
    ate_wa_sel_t wa_sel;
    ate_wd_sel_t wd_sel;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        set_status;
    ate_status_t status;
    logic        set_found;
    logic        latch_old;
    logic        set_new;
    logic        load_out;
  } ate_cmd_t;

  typedef struct packed {
    ate_kind_t kind;
    logic      empty;
    logic      full;
    logic      pos_oob;
    logic      match;
    logic      walk_last;
    logic      out_free;
  } ate_sts_t;

endpackage

// ===== hw/rtl/ate_req_if.sv =====
// ----------------------------------------------------------------------------
// ate_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface ate_req_if import ate_pkg::*; ();

  logic      valid;
  logic      ready;
  ate_kind_t kind;
  ate_word_t value;
  ate_pos_t  position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);

endinterface

// ===== hw/rtl/ate_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ate_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface ate_rsp_if import ate_pkg::*; ();

  logic        valid;
  logic        ready;
  ate_status_t status;
  ate_pos_t    found_position;
  ate_word_t   old_value;
  ate_word_t   new_value;
  ate_fill_t   fill_count;

  modport source (output valid, output status, output found_position, output old_value,
                  output new_value, output fill_count, input ready);
  modport sink   (input valid, input status, input found_position, input old_value,
                  input new_value, input fill_count, output ready);

endinterface

// ===== hw/rtl/array_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// array_table_engine_unit
// Unsorted list of signed words with fill count: search, append, modify,
// remove with shift, and zero at position.
// Search walks the entries from entry 0 until a match or the last entry;
//   remove shifts each entry after the position down one place, walking the
//   single read port of the entry RAM one entry per cycle.
// Flow: one request at a time; the next request is accepted the cycle
//   after the result is loaded; a result still waiting in the output
//   register holds the sequencer.
// Reset: fill count and handshakes clear at once; entries are not cleared.
// ----------------------------------------------------------------------------
module array_table_engine_unit import ate_pkg::*; #(
  parameter int CAPACITY = ATE_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  ate_req_if.sink   in_req,
  ate_rsp_if.source out_rsp
);

  ate_cmd_t cmd;
  ate_sts_t sts;

  ate_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ate_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_req.kind),
    .in_value    (in_req.value),
    .in_position (in_req.position),
    .cmd         (cmd),
    .sts         (sts),
    .out_rsp     (out_rsp)
  );

endmodule

// ===== hw/rtl/ate_ram.sv =====
// ----------------------------------------------------------------------------
// ate_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ate_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/ate_ctrl.sv =====
// ----------------------------------------------------------------------------
// ate_ctrl
// Request sequencer: decodes the request, walks the list for search and
// remove, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ate_ctrl import ate_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ate_sts_t sts,
  output ate_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN     = 6'b000100,
    S_FETCH    = 6'b001000,
    S_SHIFT    = 6'b010000,
    S_DONE     = 6'b100000
  } ate_state_t;

  ate_state_t state_r;
  ate_state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_ZERO;
    cmd.wa_sel = WA_TAIL;
    cmd.wd_sel = WD_VALUE;
    cmd.status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.clear_res = 1'b1;
        state_nxt     = S_DONE;
        case (sts.kind)
          KIND_SEARCH: begin
            if (sts.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOT_FOUND;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ZERO;
              state_nxt  = S_SCAN;
            end
          end
          KIND_APPEND: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wa_sel  = WA_TAIL;
              cmd.wd_sel  = WD_VALUE;
              cmd.cnt_inc = 1'b1;
            end
          end
          KIND_MODIFY, KIND_REMOVE, KIND_ZERO: begin
            if (sts.pos_oob) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
              state_nxt  = S_FETCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.walk_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_FETCH: begin
        cmd.latch_old = 1'b1;
        state_nxt     = S_DONE;
        case (sts.kind)
          KIND_MODIFY: begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_POS;
            cmd.wd_sel  = WD_VALUE;
            cmd.set_new = 1'b1;
          end
          KIND_ZERO: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_POS;
            cmd.wd_sel = WD_ZERO;
          end
          KIND_REMOVE: begin
            if (sts.walk_last) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_NEXT;
              state_nxt  = S_SHIFT;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_PREV;
        cmd.wd_sel = WD_READ;
        if (sts.walk_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !sts.empty)
    else $error("scan with an empty list");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && sts.out_free) |=> in_ready)
    else $error("result handed over but request side not reopened");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

endmodule

// ===== hw/rtl/ate_dp.sv =====
// ----------------------------------------------------------------------------
// ate_dp
// Datapath: entry store, fill count, walk pointer, result fields and the
// output register.
// ----------------------------------------------------------------------------
module ate_dp import ate_pkg::*; #(
  parameter int CAPACITY = ATE_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ate_kind_t in_kind,
  input  ate_word_t in_value,
  input  ate_pos_t  in_position,
  input  ate_cmd_t  cmd,
  output ate_sts_t  sts,
  ate_rsp_if.source out_rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int FW = (CW > FILL_W) ? CW : FILL_W;
  localparam int XW = (AW > POS_W) ? AW : POS_W;

  ate_kind_t   kind_r;
  ate_word_t   value_r;
  ate_pos_t    pos_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] addr_r;
  ate_status_t res_status_r;
  ate_pos_t    res_fpos_r;
  ate_word_t   res_old_r;
  ate_word_t   res_new_r;
  logic        out_valid_r;
  ate_status_t out_status_r;
  ate_pos_t    out_fpos_r;
  ate_word_t   out_old_r;
  ate_word_t   out_new_r;
  ate_fill_t   out_fill_r;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] count_pext;
  logic [AW-1:0] pos_addr;
  logic [FW-1:0] count_fext;
  logic [XW-1:0] addr_xext;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  ate_word_t     wr_data;
  ate_word_t     rd_data;

  assign pos_ext    = PW'(pos_r);
  assign count_pext = PW'(count_r);
  assign pos_addr   = pos_ext[AW-1:0];
  assign count_fext = FW'(count_r);
  assign addr_xext  = XW'(addr_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_POS:  rd_addr = pos_addr;
      RD_NEXT: rd_addr = addr_r + AW'(1);
      default: rd_addr = '0;
    endcase
    case (cmd.wa_sel)
      WA_POS:  wr_addr = pos_addr;
      WA_PREV: wr_addr = addr_r - AW'(1);
      default: wr_addr = count_r[AW-1:0];
    endcase
    case (cmd.wd_sel)
      WD_ZERO: wr_data = '0;
      WD_READ: wr_data = rd_data;
      default: wr_data = value_r;
    endcase
  end

  ate_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign sts.kind      = kind_r;
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r >= CW'(CAPACITY));
  assign sts.pos_oob   = (pos_ext >= count_pext);
  assign sts.match     = (rd_data == value_r);
  assign sts.walk_last = ((CW'(addr_r) + CW'(1)) == count_r);
  assign sts.out_free  = !out_valid_r || out_rsp.ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd.rd_en) begin
      addr_r <= rd_addr;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end else if (cmd.clear_res) begin
      res_status_r <= ST_OK;
    end
    if (cmd.clear_res) begin
      res_fpos_r <= '0;
      res_old_r  <= '0;
      res_new_r  <= '0;
    end else begin
      if (cmd.set_found) begin
        res_fpos_r <= addr_xext[POS_W-1:0];
      end
      if (cmd.latch_old) begin
        res_old_r <= rd_data;
      end
      if (cmd.set_new) begin
        res_new_r <= value_r;
      end
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_fpos_r   <= res_fpos_r;
      out_old_r    <= res_old_r;
      out_new_r    <= res_new_r;
      out_fill_r   <= count_fext[FILL_W-1:0];
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.found_position = out_fpos_r;
  assign out_rsp.old_value      = out_old_r;
  assign out_rsp.new_value      = out_new_r;
  assign out_rsp.fill_count     = out_fill_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten before it was taken");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> (!sts.full && cmd.wr_en && cmd.wa_sel == WA_TAIL))
    else $error("append into a full list");

  a_remove_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (!sts.empty && !cmd.cnt_inc))
    else $error("remove from an empty list");

endmodule
